// ----- design/srtf_pkg.sv -----
`timescale 1ns / 1ps

package srtf_pkg;

    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int ID_W     = 8;
    localparam int TIME_W   = 16;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 64;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESULT
    } t_state;

    // one row of the job table
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] burst;
    } t_entry;

    // scan control from the sequencer to the compare unit
    typedef struct packed {
        logic             clear;
        logic             rd_valid;
        logic [IDX_W-1:0] rd_idx;
        logic             done_bit;
    } t_scan;

    // running best candidate held by the compare unit
    typedef struct packed {
        logic             have;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_pick;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [5:0]        pad;
        logic              all_done;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] turnaround;
        logic              finished;
        logic [TIME_W-1:0] time_after;
        logic [ID_W-1:0]   running_id;
    } t_result;

    // input word, last field in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] arrival;
        logic [ID_W-1:0]   job_id;
    } t_job_in;

endpackage

// ----- design/srtf_job_ram.sv -----
`timescale 1ns / 1ps

module srtf_job_ram (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [srtf_pkg::IDX_W-1:0]   i_waddr,
    input  srtf_pkg::t_entry             i_wdata,
    input  logic [srtf_pkg::IDX_W-1:0]   i_raddr,
    output srtf_pkg::t_entry             o_rdata
);

    srtf_pkg::t_entry r_mem [srtf_pkg::MAX_JOBS];
    srtf_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/srtf_pick_unit.sv -----
`timescale 1ns / 1ps

module srtf_pick_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srtf_pkg::t_scan               i_scan,
    input  srtf_pkg::t_entry              i_entry,
    input  logic [srtf_pkg::TIME_W-1:0]   i_cur_time,
    output srtf_pkg::t_pick               o_pick
);

    logic                         r_have, n_have;
    logic [srtf_pkg::IDX_W-1:0]   r_idx, n_idx;
    srtf_pkg::t_entry             r_entry, n_entry;
    logic                         eligible;
    logic                         better;

    // ready and not done; strict less-than keeps the earlier row on a tie
    assign eligible = !i_scan.done_bit && (i_entry.arrival <= i_cur_time);
    assign better   = !r_have || (i_entry.remaining < r_entry.remaining);

    always_comb begin
        n_have  = r_have;
        n_idx   = r_idx;
        n_entry = r_entry;
        if (i_scan.clear) begin
            n_have = 1'b0;
        end else if (i_scan.rd_valid && eligible && better) begin
            n_have  = 1'b1;
            n_idx   = i_scan.rd_idx;
            n_entry = i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else begin
            r_have <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_entry <= n_entry;
    end

    assign o_pick.have  = r_have;
    assign o_pick.idx   = r_idx;
    assign o_pick.entry = r_entry;

endmodule

// ----- design/srtf_tick_scheduler_core.sv -----
`timescale 1ns / 1ps

// Shortest-remaining-time-first scheduler over a table of up to MAX_JOBS jobs.
// Slave channel: tuser carries the operation (add a job or run one tick),
// tdata carries job_id, arrival and burst. An add is stored in the cycle of its
// transfer and gives no result; an add to a full table is dropped.
// A tick scans the table one row per cycle through a single comparator. Its
// result is loaded in the result state, after the scan and update states, and
// the next item can be taken in the cycle after; no new item is taken while a
// tick is in progress, and the single table RAM read port sets the pace.
// Master channel: one result per tick. tuser is the idle flag, tdata carries
// running_id, time_after, finished, turnaround, waiting and all_done.
// The result sits in an output register; the next item is taken while it waits
// for the receiver. If the receiver stalls, a finished tick holds in its result
// state until the register frees, and tready stays low meanwhile.
// Reset clears the job count, finished count, time counter, done marks and
// output valid; no clearing pass is needed, the table is ready at once.
module srtf_tick_scheduler_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // job_id[7:0], arrival[23:8], burst[39:24]
    input  logic [srtf_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    // op[0]
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // running_id[7:0], time_after[23:8], finished[24], turnaround[40:25],
    // waiting[56:41], all_done[57], zero fill[63:58]
    output logic [srtf_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    // idle[0]
    output logic                            o_m_axis_tuser
);

    localparam logic [srtf_pkg::TIME_W-1:0] TIME_MAX = {srtf_pkg::TIME_W{1'b1}};

    srtf_pkg::t_state                 r_state, n_state;
    logic [srtf_pkg::CNT_W-1:0]       r_job_cnt, n_job_cnt;
    logic [srtf_pkg::CNT_W-1:0]       r_fin_cnt, n_fin_cnt;
    logic [srtf_pkg::TIME_W-1:0]      r_time, n_time;
    logic [srtf_pkg::MAX_JOBS-1:0]    r_done, n_done;
    logic [srtf_pkg::CNT_W-1:0]       r_idx, n_idx;
    logic                             r_rd_v, n_rd_v;
    logic [srtf_pkg::IDX_W-1:0]       r_rd_idx, n_rd_idx;
    logic                             r_fin, n_fin;
    logic [srtf_pkg::TIME_W-1:0]      r_tat, n_tat;
    logic                             r_out_valid, n_out_valid;
    logic                             r_out_idle, n_out_idle;
    srtf_pkg::t_result                r_out, n_out;

    srtf_pkg::t_job_in                job_in;
    srtf_pkg::t_op                    op_in;
    logic                             s_fire;
    logic                             ram_we;
    logic [srtf_pkg::IDX_W-1:0]       ram_waddr;
    srtf_pkg::t_entry                 ram_wdata;
    srtf_pkg::t_entry                 ram_rdata;
    logic                             scan_clear;
    srtf_pkg::t_scan                  scan;
    srtf_pkg::t_pick                  pick;
    logic [srtf_pkg::TIME_W-1:0]      time_next;
    logic [srtf_pkg::TIME_W-1:0]      rem_next;

    assign job_in = srtf_pkg::t_job_in'(i_s_axis_tdata);
    assign op_in  = srtf_pkg::t_op'(i_s_axis_tuser);
    assign o_s_axis_tready = (r_state == srtf_pkg::ST_IDLE);
    assign s_fire = i_s_axis_tvalid && o_s_axis_tready;

    // saturating time step and the picked job's new remaining time
    assign time_next = (r_time == TIME_MAX) ? r_time : r_time + srtf_pkg::TIME_W'(1);
    assign rem_next  = pick.entry.remaining - srtf_pkg::TIME_W'(1);

    srtf_job_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[srtf_pkg::IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    srtf_pick_unit u_pick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_scan     (scan),
        .i_entry    (ram_rdata),
        .i_cur_time (r_time),
        .o_pick     (pick)
    );

    assign scan.clear    = scan_clear;
    assign scan.rd_valid = r_rd_v;
    assign scan.rd_idx   = r_rd_idx;
    assign scan.done_bit = r_done[r_rd_idx];

    always_comb begin
        n_state     = r_state;
        n_job_cnt   = r_job_cnt;
        n_fin_cnt   = r_fin_cnt;
        n_time      = r_time;
        n_done      = r_done;
        n_idx       = r_idx;
        n_rd_v      = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_fin       = r_fin;
        n_tat       = r_tat;
        n_out       = r_out;
        n_out_idle  = r_out_idle;
        // drop the valid once the receiver takes the result
        n_out_valid = r_out_valid && !i_m_axis_tready;
        ram_we      = 1'b0;
        ram_waddr   = r_job_cnt[srtf_pkg::IDX_W-1:0];
        ram_wdata   = '{id: job_in.job_id, arrival: job_in.arrival,
                        remaining: job_in.burst, burst: job_in.burst};
        scan_clear  = 1'b0;

        // an empty burst is stored as one tick
        if (job_in.burst == '0) begin
            ram_wdata.remaining = srtf_pkg::TIME_W'(1);
            ram_wdata.burst     = srtf_pkg::TIME_W'(1);
        end

        case (r_state)
            srtf_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (op_in == srtf_pkg::OP_ADD) begin
                        if (r_job_cnt != srtf_pkg::CNT_W'(srtf_pkg::MAX_JOBS)) begin
                            ram_we    = 1'b1;
                            n_done[r_job_cnt[srtf_pkg::IDX_W-1:0]] = 1'b0;
                            n_job_cnt = r_job_cnt + srtf_pkg::CNT_W'(1);
                        end
                    end else begin
                        scan_clear = 1'b1;
                        n_idx      = '0;
                        n_state    = srtf_pkg::ST_SCAN;
                    end
                end
            end
            srtf_pkg::ST_SCAN: begin
                // issue one row per cycle; the compare unit sees it in the cycle after
                if (r_idx != r_job_cnt) begin
                    n_rd_v   = 1'b1;
                    n_rd_idx = r_idx[srtf_pkg::IDX_W-1:0];
                    n_idx    = r_idx + srtf_pkg::CNT_W'(1);
                end else begin
                    n_state = srtf_pkg::ST_UPDATE;
                end
            end
            srtf_pkg::ST_UPDATE: begin
                n_time = time_next;
                n_fin  = 1'b0;
                n_tat  = '0;
                if (pick.have) begin
                    ram_we              = 1'b1;
                    ram_waddr           = pick.idx;
                    ram_wdata           = pick.entry;
                    ram_wdata.remaining = rem_next;
                    if (rem_next == '0) begin
                        n_done[pick.idx] = 1'b1;
                        n_fin_cnt        = r_fin_cnt + srtf_pkg::CNT_W'(1);
                        n_fin            = 1'b1;
                        n_tat            = time_next - pick.entry.arrival;
                    end
                end
                n_state = srtf_pkg::ST_RESULT;
            end
            srtf_pkg::ST_RESULT: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid        = 1'b1;
                    n_out_idle         = !pick.have;
                    n_out.pad          = '0;
                    n_out.running_id   = pick.have ? pick.entry.id : '0;
                    n_out.time_after   = r_time;
                    n_out.finished     = r_fin;
                    n_out.turnaround   = r_tat;
                    n_out.waiting      = (r_fin && (r_tat >= pick.entry.burst))
                                         ? r_tat - pick.entry.burst : '0;
                    n_out.all_done     = (r_fin_cnt == r_job_cnt);
                    n_state            = srtf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srtf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srtf_pkg::ST_IDLE;
            r_job_cnt   <= '0;
            r_fin_cnt   <= '0;
            r_time      <= '0;
            r_done      <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job_cnt   <= n_job_cnt;
            r_fin_cnt   <= n_fin_cnt;
            r_time      <= n_time;
            r_done      <= n_done;
            r_rd_v      <= n_rd_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_fin      <= n_fin;
        r_tat      <= n_tat;
        r_out      <= n_out;
        r_out_idle <= n_out_idle;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;
    assign o_m_axis_tuser  = r_out_idle;

    // a tick transfer closes the input until its result is loaded
    a_tick_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && (op_in == srtf_pkg::OP_TICK)) |=> !o_s_axis_tready)
        else $error("input still open after a tick transfer");

    // never more completions than loaded jobs
    a_fin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_cnt <= r_job_cnt)
        else $error("finished count exceeds job count");

    // an idle tick names no job and finishes nothing
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_idle) |-> (r_out.running_id == '0 && !r_out.finished))
        else $error("idle result carries a job");

    // the scan never reads beyond the loaded rows
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srtf_pkg::ST_SCAN) |-> (r_idx <= r_job_cnt))
        else $error("scan index past job count");

endmodule

// ----- tb/tb_srtf_tick_scheduler_core.sv -----
`timescale 1ns / 1ps

module tb_srtf_tick_scheduler_core;

    localparam int CLK_HALF   = 4;
    localparam int RST_CYCLES = 10;
    localparam int RAND_ITEMS = 1180;
    localparam int TAIL_WAIT  = 48;
    localparam int CYC_LIMIT  = 400000;
    localparam logic [srtf_pkg::TIME_W-1:0] TIME_TOP = '1;

    // one scheduler answer, as the predictor sees it
    typedef struct packed {
        logic                        idle;
        logic [srtf_pkg::ID_W-1:0]   run_id;
        logic [srtf_pkg::TIME_W-1:0] t_after;
        logic                        fin;
        logic [srtf_pkg::TIME_W-1:0] tat;
        logic [srtf_pkg::TIME_W-1:0] wt;
        logic                        all_done;
    } t_sched_out;

    typedef struct packed {
        srtf_pkg::t_op               op;
        logic [srtf_pkg::ID_W-1:0]   id;
        logic [srtf_pkg::TIME_W-1:0] arr;
        logic [srtf_pkg::TIME_W-1:0] burst;
        logic                        typed;
        t_sched_out                  want;
    } t_dir_row;

    localparam t_sched_out NO_CHECK = '0;
    localparam int N_DIR = 13;

    // directed opening: empty table, zero burst, id and arrival extremes,
    // a job that is not ready yet, a tie on remaining time, a maximum burst
    t_dir_row dir_rows [N_DIR] = '{
        '{srtf_pkg::OP_TICK, 8'd0,   16'd0,     16'd0,     1'b1,
          '{1'b1, 8'd0,   16'd1, 1'b0, 16'd0, 16'd0, 1'b1}},
        '{srtf_pkg::OP_ADD,  8'd255, 16'd0,     16'd0,     1'b0, NO_CHECK},
        '{srtf_pkg::OP_TICK, 8'd0,   16'd0,     16'd0,     1'b1,
          '{1'b0, 8'd255, 16'd2, 1'b1, 16'd2, 16'd1, 1'b1}},
        '{srtf_pkg::OP_ADD,  8'd0,   16'hFFFF,  16'd3,     1'b0, NO_CHECK},
        '{srtf_pkg::OP_TICK, 8'd0,   16'd0,     16'd0,     1'b1,
          '{1'b1, 8'd0,   16'd3, 1'b0, 16'd0, 16'd0, 1'b0}},
        '{srtf_pkg::OP_ADD,  8'h5A,  16'd3,     16'd2,     1'b0, NO_CHECK},
        '{srtf_pkg::OP_ADD,  8'hA5,  16'd3,     16'd2,     1'b0, NO_CHECK},
        '{srtf_pkg::OP_TICK, 8'hFF,  16'hFFFF,  16'hFFFF,  1'b0, NO_CHECK},
        '{srtf_pkg::OP_TICK, 8'd0,   16'd0,     16'd0,     1'b0, NO_CHECK},
        '{srtf_pkg::OP_TICK, 8'h0F,  16'h00FF,  16'hFF00,  1'b0, NO_CHECK},
        '{srtf_pkg::OP_TICK, 8'd0,   16'd0,     16'd0,     1'b0, NO_CHECK},
        '{srtf_pkg::OP_ADD,  8'h33,  16'd0,     16'hFFFF,  1'b0, NO_CHECK},
        '{srtf_pkg::OP_TICK, 8'd0,   16'd0,     16'd0,     1'b0, NO_CHECK}
    };

    logic                          clk     = 1'b0;
    logic                          rst_n   = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [srtf_pkg::S_DATA_W-1:0] s_data  = '0;
    logic                          s_user  = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [srtf_pkg::M_DATA_W-1:0] m_data;
    logic                          m_user;

    // predictor copy of the job table
    logic [srtf_pkg::ID_W-1:0]   tbl_id    [srtf_pkg::MAX_JOBS];
    logic [srtf_pkg::TIME_W-1:0] tbl_arr   [srtf_pkg::MAX_JOBS];
    logic [srtf_pkg::TIME_W-1:0] tbl_rem   [srtf_pkg::MAX_JOBS];
    logic [srtf_pkg::TIME_W-1:0] tbl_burst [srtf_pkg::MAX_JOBS];
    logic                        tbl_done  [srtf_pkg::MAX_JOBS];
    int                          n_loaded   = 0;
    int                          n_finished = 0;
    logic [srtf_pkg::TIME_W-1:0] clock_now  = '0;

    t_sched_out sched_due [$];
    int         err_cnt    = 0;
    int         cyc_cnt    = 0;
    int         burst_left = 0;

    srtf_tick_scheduler_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always #(CLK_HALF) clk = ~clk;

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            flag_error($sformatf("%s expected %0d got %0d", name, want, got));
        end
    endtask

    // store one job; a full table drops it, a zero burst counts as one
    function automatic void store_job(input logic [srtf_pkg::ID_W-1:0] id,
                                      input logic [srtf_pkg::TIME_W-1:0] arr,
                                      input logic [srtf_pkg::TIME_W-1:0] burst);
        logic [srtf_pkg::TIME_W-1:0] b;
        if (n_loaded >= srtf_pkg::MAX_JOBS) begin
            return;
        end
        b = (burst == '0) ? srtf_pkg::TIME_W'(1) : burst;
        tbl_id[n_loaded]    = id;
        tbl_arr[n_loaded]   = arr;
        tbl_rem[n_loaded]   = b;
        tbl_burst[n_loaded] = b;
        tbl_done[n_loaded]  = 1'b0;
        n_loaded++;
    endfunction

    // serve one time unit: least remaining among ready jobs, earliest on a tie
    function automatic t_sched_out run_tick();
        t_sched_out                  r;
        int                          pick;
        logic [srtf_pkg::TIME_W-1:0] best;
        r    = '0;
        pick = -1;
        best = '0;
        for (int k = 0; k < n_loaded; k++) begin
            if (!tbl_done[k] && tbl_arr[k] <= clock_now) begin
                if (pick < 0 || tbl_rem[k] < best) begin
                    best = tbl_rem[k];
                    pick = k;
                end
            end
        end
        if (clock_now != TIME_TOP) begin
            clock_now++;
        end
        r.t_after = clock_now;
        if (pick < 0) begin
            r.idle = 1'b1;
        end else begin
            r.run_id = tbl_id[pick];
            if (tbl_rem[pick] != '0) begin
                tbl_rem[pick]--;
            end
            if (tbl_rem[pick] == '0) begin
                tbl_done[pick] = 1'b1;
                n_finished++;
                r.fin = 1'b1;
                r.tat = clock_now - tbl_arr[pick];
                r.wt  = (r.tat >= tbl_burst[pick]) ? r.tat - tbl_burst[pick] : '0;
            end
        end
        r.all_done = (n_finished == n_loaded);
        return r;
    endfunction

    // offer one item, hold it until the transfer, then predict its answer
    task automatic offer(input srtf_pkg::t_op op, input logic [srtf_pkg::ID_W-1:0] id,
                         input logic [srtf_pkg::TIME_W-1:0] arr,
                         input logic [srtf_pkg::TIME_W-1:0] burst,
                         input logic typed, input t_sched_out want);
        int         gap;
        t_sched_out r;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge clk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_user  <= op;
        // burst, arrival, job_id from the top bits down
        s_data  <= {burst, arr, id};
        do @(posedge clk); while (!s_ready);
        if (op == srtf_pkg::OP_TICK) begin
            r = run_tick();
            sched_due.push_back(typed ? want : r);
        end else begin
            store_job(id, arr, burst);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // drop valid and hold until every pending answer has come back
    task automatic hold_until_empty();
        @(negedge clk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (sched_due.size() != 0) @(posedge clk);
    endtask

    // receiver: stall a random slice of each repeating window
    always @(negedge clk) begin
        static int rx_pos   = 0;
        static int rx_len   = 1;
        static int rx_stall = 0;
        if (rx_pos == 0) begin
            rx_len   = $urandom_range(1, 24);
            rx_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rx_len - 1);
        end
        m_ready <= (rx_pos >= rx_stall);
        rx_pos = (rx_pos + 1) % rx_len;
    end

    // compare each result transfer with the oldest pending answer
    always @(posedge clk) begin
        srtf_pkg::t_result got;
        t_sched_out        want;
        if (rst_n && m_valid && m_ready) begin
            got = srtf_pkg::t_result'(m_data);
            if (sched_due.size() == 0) begin
                flag_error("result transfer with no tick pending");
            end else begin
                want = sched_due.pop_front();
                check_field("idle",       want.idle,     m_user);
                check_field("running_id", want.run_id,   got.running_id);
                check_field("time_after", want.t_after,  got.time_after);
                check_field("finished",   want.fin,      got.finished);
                check_field("turnaround", want.tat,      got.turnaround);
                check_field("waiting",    want.wt,       got.waiting);
                check_field("all_done",   want.all_done, got.all_done);
                check_field("zero fill",  0,             got.pad);
            end
        end
    end

    always @(posedge clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYC_LIMIT) begin
            $display("tb_srtf_tick_scheduler_core failed");
            $finish;
        end
    end

    initial begin
        int                          placed;
        int                          a;
        bit                          do_add;
        logic [srtf_pkg::TIME_W-1:0] br;
        repeat (RST_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            offer(dir_rows[i].op, dir_rows[i].id, dir_rows[i].arr, dir_rows[i].burst,
                  dir_rows[i].typed, dir_rows[i].want);
        end
        hold_until_empty();

        // random part: mix ticks with adds of mostly short jobs, mostly near the
        // current time, until the table is full; adds to a full table are noise
        placed = 0;
        while (placed < RAND_ITEMS) begin
            if (placed == RAND_ITEMS / 2) begin
                hold_until_empty();
            end
            if (n_loaded < srtf_pkg::MAX_JOBS) begin
                do_add = ($urandom_range(0, 5) == 0);
            end else begin
                do_add = ($urandom_range(0, 19) == 0);
            end
            if (!do_add) begin
                offer(srtf_pkg::OP_TICK, srtf_pkg::ID_W'($urandom),
                      srtf_pkg::TIME_W'($urandom), srtf_pkg::TIME_W'($urandom),
                      1'b0, NO_CHECK);
                placed++;
            end else if (n_loaded < srtf_pkg::MAX_JOBS) begin
                if ($urandom_range(0, 3) == 0) begin
                    a = $urandom_range(0, 65535);
                end else begin
                    a = int'(clock_now) + $urandom_range(0, 40);
                    if (a > 65535) begin
                        a = 65535;
                    end
                end
                br = ($urandom_range(0, 4) == 0)
                     ? srtf_pkg::TIME_W'($urandom_range(0, 400))
                     : srtf_pkg::TIME_W'($urandom_range(0, 24));
                offer(srtf_pkg::OP_ADD, srtf_pkg::ID_W'($urandom), srtf_pkg::TIME_W'(a),
                      br, 1'b0, NO_CHECK);
                placed++;
            end else begin
                offer(srtf_pkg::OP_ADD, srtf_pkg::ID_W'($urandom),
                      srtf_pkg::TIME_W'($urandom), srtf_pkg::TIME_W'($urandom),
                      1'b0, NO_CHECK);
            end
        end

        hold_until_empty();
        repeat (TAIL_WAIT) @(posedge clk);
        if (sched_due.size() != 0) begin
            flag_error($sformatf("%0d answers never arrived", sched_due.size()));
        end
        if (err_cnt == 0) begin
            $display("tb_srtf_tick_scheduler_core passed");
        end else begin
            $display("tb_srtf_tick_scheduler_core failed");
        end
        $finish;
    end

endmodule
